// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the IIR filter block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in one cycle implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`endif

// ===== hw/rtl/iir3_pkg.sv =====
// Shared types, widths, defaults and reset coefficients of the third-order IIR filter.
// No dependencies.
`timescale 1ns / 1ps

package iir3_pkg;

  localparam int FEEDFORWARD_TAPS_DEF = 4;
  localparam int FEEDBACK_TAPS_DEF    = 3;
  localparam int COEF_FRAC_BITS_DEF   = 15;

  localparam int COEF_W    = 18;
  localparam int SAMPLE_W  = 16;
  localparam int CFG_IDX_W = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic rotate;
    logic load_sample;
    logic load_coef;
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic mul_en;
    logic neg;
  } mac_ctrl_t;

  // Reset coefficient of ring position idx; extra taps reset to zero.
  function automatic logic signed [COEF_W-1:0] default_coef(input int idx, input int ff);
    logic signed [COEF_W-1:0] c;
    int j;
    c = '0;
    j = idx - ff;
    if (idx < ff) begin
      if (idx == 0) c = 18'sd141;
      else if (idx == 1) c = 18'sd423;
      else if (idx == 2) c = 18'sd423;
      else if (idx == 3) c = 18'sd141;
    end else begin
      if (j == 0) c = -18'sd79921;
      else if (j == 1) c = 18'sd69534;
      else if (j == 2) c = -18'sd21260;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/iir3_cell.sv =====
// One tap cell of the coefficient/sample ring: holds a coefficient and a sample.
// Depends on iir3_pkg.
`timescale 1ns / 1ps

module iir3_cell #(
  parameter logic signed [iir3_pkg::COEF_W-1:0] RESET_COEF = '0
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  iir3_pkg::cell_ctrl_t                  ctrl_i,
  input  logic signed [iir3_pkg::COEF_W-1:0]    rot_coef_i,
  input  logic signed [iir3_pkg::SAMPLE_W-1:0]  rot_sample_i,
  input  logic signed [iir3_pkg::SAMPLE_W-1:0]  load_sample_i,
  input  logic signed [iir3_pkg::COEF_W-1:0]    cfg_data_i,
  output logic signed [iir3_pkg::COEF_W-1:0]    coef_o,
  output logic signed [iir3_pkg::SAMPLE_W-1:0]  sample_o
);
  import iir3_pkg::*;

  logic signed [COEF_W-1:0]   coef_q, coef_d;
  logic signed [SAMPLE_W-1:0] sample_q, sample_d;

  // Coefficient and sample loads are independent; rotation overrides both.
  always_comb begin
    coef_d   = coef_q;
    sample_d = sample_q;
    if (ctrl_i.rotate) begin
      coef_d   = rot_coef_i;
      sample_d = rot_sample_i;
    end else begin
      if (ctrl_i.load_coef) coef_d = cfg_data_i;
      if (ctrl_i.load_sample) sample_d = load_sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q   <= RESET_COEF;
      sample_q <= '0;
    end else begin
      coef_q   <= coef_d;
      sample_q <= sample_d;
    end
  end

  assign coef_o   = coef_q;
  assign sample_o = sample_q;

endmodule

// ===== hw/rtl/iir3_mac.sv =====
// Multiply-accumulate unit at the head of the ring, with output shift and saturation.
// Depends on iir3_pkg.
`timescale 1ns / 1ps

module iir3_mac #(
  parameter int NUM_TAPS       = iir3_pkg::FEEDFORWARD_TAPS_DEF + iir3_pkg::FEEDBACK_TAPS_DEF,
  parameter int COEF_FRAC_BITS = iir3_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  iir3_pkg::mac_ctrl_t                   ctrl_i,
  input  logic signed [iir3_pkg::COEF_W-1:0]    coef_i,
  input  logic signed [iir3_pkg::SAMPLE_W-1:0]  sample_i,
  output logic signed [iir3_pkg::SAMPLE_W-1:0]  y_o,
  output logic                                  clip_o
);
  import iir3_pkg::*;

  localparam int PROD_W = COEF_W + SAMPLE_W;
  localparam int ACC_W  = PROD_W + $clog2(NUM_TAPS) + 1;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_d;
  logic                     acc_en_q;
  logic                     neg_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-SAMPLE_W:0]  hi_bits;
  logic                     ovf;

  assign prod_d   = coef_i * sample_i;
  assign prod_ext = ACC_W'(prod_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
      neg_q  <= ctrl_i.neg;
    end
  end

  always_comb begin
    acc_d = acc_q;
    priority if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (acc_en_q) begin
      acc_d = neg_q ? (acc_q - prod_ext) : (acc_q + prod_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_en_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      acc_en_q <= ctrl_i.mul_en;
      acc_q    <= acc_d;
    end
  end

  // Arithmetic shift floors toward minus infinity; in range when the top bits agree.
  assign shifted = acc_q >>> COEF_FRAC_BITS;
  assign hi_bits = shifted[ACC_W-1:SAMPLE_W-1];
  assign ovf     = !((&hi_bits) || (~|hi_bits));

  always_comb begin
    if (ovf) begin
      y_o = acc_q[ACC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      y_o = shifted[SAMPLE_W-1:0];
    end
  end

  assign clip_o = ovf;

endmodule

// ===== hw/rtl/iir_third_order_direct_form_one_unit.sv =====
// Top level of the third-order direct form I IIR filter: ring of tap cells, MAC, control.
// Depends on iir3_pkg, iir3_cell and iir3_mac.
`timescale 1ns / 1ps

// Each accepted sample occupies the block through an accept step in idle, a MAC step in
// which the ring of coefficient/sample cells rotates past the single multiply-accumulate
// unit at its head, one tap per cycle, a drain step for the product register, and a
// write-back step that shifts the input and output histories and loads the output
// register. The next sample is taken the cycle after write-back; write-back waits while
// a previous result is still held and stalled. The configuration port is ready only
// while the block is idle, so coefficients are written while no sample is in flight.
module iir_third_order_direct_form_one_unit #(
  parameter int FEEDFORWARD_TAPS = iir3_pkg::FEEDFORWARD_TAPS_DEF,
  parameter int FEEDBACK_TAPS    = iir3_pkg::FEEDBACK_TAPS_DEF,
  parameter int COEF_FRAC_BITS   = iir3_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [iir3_pkg::SAMPLE_W-1:0]  sample_in_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [iir3_pkg::SAMPLE_W-1:0]  sample_out_o,
  output logic                                  clipped_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [iir3_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic signed [iir3_pkg::COEF_W-1:0]    cfg_data_i
);
  import iir3_pkg::*;

  localparam int NUM_TAPS = FEEDFORWARD_TAPS + FEEDBACK_TAPS;
  localparam int CNT_W    = $clog2(NUM_TAPS);

  state_e                     state_q, state_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       last_tap;
  logic                       accept;
  logic                       finish;
  logic                       out_free;

  logic                       out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] sample_out_q;
  logic                       clipped_q;

  cell_ctrl_t                 cell_ctrl [NUM_TAPS];
  logic signed [COEF_W-1:0]   coef_w    [NUM_TAPS];
  logic signed [SAMPLE_W-1:0] sample_w  [NUM_TAPS];
  mac_ctrl_t                  mac_ctrl;
  logic signed [SAMPLE_W-1:0] y;
  logic                       clip;

  assign last_tap = (cnt_q == CNT_W'(NUM_TAPS - 1));
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_MAC;
      ST_MAC:   if (last_tap) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall_o       = 1'b1;
    accept           = 1'b0;
    finish           = 1'b0;
    mac_ctrl.clear   = 1'b0;
    mac_ctrl.mul_en  = 1'b0;
    mac_ctrl.neg     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o     = 1'b0;
        accept         = in_valid_i;
        mac_ctrl.clear = in_valid_i;
      end
      ST_MAC: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.neg    = (cnt_q >= CNT_W'(FEEDFORWARD_TAPS));
      end
      ST_DRAIN: ;
      ST_DONE: finish = out_free;
      default: ;
    endcase
  end

  always_comb begin
    cnt_d = '0;
    if (state_q == ST_MAC && !last_tap) cnt_d = cnt_q + 1'b1;
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (finish) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      sample_out_q <= y;
      clipped_q    <= clip;
    end
  end

  // Ring: cell i takes its neighbor i+1 on rotate; history shift takes from i-1.
  for (genvar i = 0; i < NUM_TAPS; i++) begin : g_cell
    localparam int NXT = (i + 1) % NUM_TAPS;
    logic signed [SAMPLE_W-1:0] load_src;

    if (i == 0) begin : g_head
      assign load_src                 = sample_in_i;
      assign cell_ctrl[i].load_sample = accept;
    end else if (i == FEEDFORWARD_TAPS) begin : g_fb_head
      assign load_src                 = y;
      assign cell_ctrl[i].load_sample = finish;
    end else begin : g_body
      assign load_src                 = sample_w[i-1];
      assign cell_ctrl[i].load_sample = finish;
    end

    assign cell_ctrl[i].rotate    = (state_q == ST_MAC);
    assign cell_ctrl[i].load_coef = cfg_valid_i && cfg_ready_o &&
                                    (cfg_index_i == CFG_IDX_W'(i));

    iir3_cell #(
      .RESET_COEF(default_coef(i, FEEDFORWARD_TAPS))
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl[i]),
      .rot_coef_i   (coef_w[NXT]),
      .rot_sample_i (sample_w[NXT]),
      .load_sample_i(load_src),
      .cfg_data_i   (cfg_data_i),
      .coef_o       (coef_w[i]),
      .sample_o     (sample_w[i])
    );
  end

  iir3_mac #(
    .NUM_TAPS      (NUM_TAPS),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .coef_i  (coef_w[0]),
    .sample_i(sample_w[0]),
    .y_o     (y),
    .clip_o  (clip)
  );

  // Coefficients sit at their register positions only while the ring is at rest.
  assign cfg_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign clipped_o    = clipped_q;

endmodule

// ===== hw/rtl/iir3_checker.sv =====
// Port-level checks of the IIR filter top level, bound to every instance.
// Depends on assert_macros.svh and iir_third_order_direct_form_one_unit.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module iir3_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i
);

  // A stalled result stays offered.
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // After a transaction on the input the block is busy with that sample.
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // A result never shows up right after an input transaction.
  `ASSERT_NEXT(a_no_early_result, clk_i, rst_ni, in_valid_i && !in_stall_o,
               !$rose(out_valid_o))

  // Going back to idle coincides with a result being offered.
  `ASSERT_SAME(a_idle_with_result, clk_i, rst_ni, $fell(in_stall_o), out_valid_o)

endmodule

bind iir_third_order_direct_form_one_unit iir3_checker u_iir3_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i)
);
